### hdl/ratsm_pkg.sv
// Shared types and constants for the range affine sum block.
// No dependencies; imported by every module in hdl/.
package ratsm_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_VALUE_BITS   = 31;

  localparam logic [30:0] RESET_MODULUS = 31'h7FFF_FFFF;
  localparam logic [10:0] RESET_COUNT   = 11'd1024;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MUL   = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_COUNT   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_EVAL,
    ST_MUL,
    ST_RESP
  } state_e;

endpackage

### hdl/range_affine_sum_tree_mod_core.sv
// Range multiply / add / sum over residues mod a programmable modulus.
// Operand reduction runs first, in the serial modular multiplier; a load then ends.
// Range ops walk the element store: each element is read, then evaluated;
// multiply then runs the serial modular multiplier on it; one item at a time.
// Reset and every modulus write clear all MAX_ELEMENTS entries, no input taken meanwhile.
module range_affine_sum_tree_mod_core import ratsm_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  first_index_i,
  input  logic [9:0]  last_index_i,
  input  logic [30:0] operand_value_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] range_sum_o,
  output logic        range_error_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // internal value width: modulus is at most 31 bits
  localparam int W  = (VALUE_BITS < 31) ? VALUE_BITS : 31;
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  state_e         state_q, state_d;
  logic [W-1:0]   mod_q;
  logic [10:0]    cnt_q;
  logic [AW-1:0]  clr_addr_q, addr_q, first_q, last_q;
  action_e        act_q;
  logic [W-1:0]   v_q, acc_q;
  logic           out_valid_q, out_err_q, err_q;
  logic [30:0]    out_sum_q;

  logic [W-1:0]   m_eff, one_eff;
  logic [16:0]    cnt_ext, cnt_eff;
  logic           bad, in_acc, cfg_wr, mod_wr, last_hit, resp_load;

  // memory and multiplier hookup
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [W-1:0]   mem_wdata, mem_rdata;
  logic           mm_start, mm_busy, mm_done;
  logic [W-1:0]   mm_a, mm_b, mm_res;

  function automatic logic [W-1:0] add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  // modulus zero behaves as modulus one
  assign m_eff   = (mod_q == '0) ? W'(1) : mod_q;
  assign one_eff = (m_eff == W'(1)) ? '0 : W'(1);

  assign cnt_ext = {6'b0, cnt_q};
  assign cnt_eff = (cnt_ext > 17'(MAX_ELEMENTS)) ? 17'(MAX_ELEMENTS) : cnt_ext;

  always_comb begin
    if (action_i == ACT_LOAD) begin
      bad = {7'b0, first_index_i} >= cnt_eff;
    end else begin
      bad = (first_index_i > last_index_i) || ({7'b0, last_index_i} >= cnt_eff);
    end
  end

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign mod_wr  = cfg_wr && (reg_idx_e'(paddr[2]) == REG_MODULUS);
  assign prdata  = (reg_idx_e'(paddr[2]) == REG_COUNT) ? 32'(cnt_q) : 32'(mod_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_hit   = (addr_q == last_q);
  assign resp_load  = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // next state, memory and multiplier control
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mm_start  = 1'b0;
    mm_a      = one_eff;
    mm_b      = operand_value_i[W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        if (clr_addr_q == AW'(MAX_ELEMENTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (bad) begin
            state_d = ST_RESP;
          end else begin
            mm_start = 1'b1;
            state_d  = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          if (act_q == ACT_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = first_q;
            mem_wdata = mm_res;
            state_d   = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        mm_a = mem_rdata;
        mm_b = v_q;
        if (act_q == ACT_MUL) begin
          mm_start = 1'b1;
          state_d  = ST_MUL;
        end else begin
          if (act_q == ACT_ADD) begin
            mem_we    = 1'b1;
            mem_wdata = add_mod(mem_rdata, v_q, m_eff);
          end
          if (!last_hit) begin
            state_d = ST_READ;
          end else if (act_q == ACT_QUERY) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          mem_we    = 1'b1;
          mem_wdata = mm_res;
          state_d   = last_hit ? ST_IDLE : ST_READ;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a modulus write wipes the store
    if (mod_wr) begin
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      mod_q       <= W'(RESET_MODULUS);
      cnt_q       <= RESET_COUNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (reg_idx_e'(paddr[2]) == REG_MODULUS) begin
          mod_q <= pwdata[W-1:0];
        end else begin
          cnt_q <= pwdata[10:0];
        end
      end
      if (mod_wr) begin
        clr_addr_q <= '0;
      end else if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload and walk registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= action_e'(action_i);
      first_q <= AW'(first_index_i);
      last_q  <= AW'(last_index_i);
      addr_q  <= AW'(first_index_i);
      err_q   <= bad;
      acc_q   <= '0;
    end
    if (state_q == ST_REDUCE && mm_done) begin
      v_q <= mm_res;
    end
    if (state_q == ST_EVAL) begin
      if (act_q == ACT_QUERY) begin
        acc_q <= add_mod(acc_q, mem_rdata, m_eff);
      end
      if (act_q != ACT_MUL && !last_hit) begin
        addr_q <= addr_q + AW'(1);
      end
    end
    if (state_q == ST_MUL && mm_done && !last_hit) begin
      addr_q <= addr_q + AW'(1);
    end
    if (resp_load) begin
      out_sum_q <= err_q ? '0 : 31'(acc_q);
      out_err_q <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign range_sum_o   = out_sum_q;
  assign range_error_o = out_err_q;

  ratsm_elem_ram #(
    .DEPTH(MAX_ELEMENTS),
    .AW   (AW),
    .W    (W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(addr_q),
    .rdata_o(mem_rdata)
  );

  ratsm_mulmod #(
    .W(W)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (m_eff),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  // an error result never carries a sum
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> range_sum_o == '0)
    else $error("error result with nonzero sum");

  // multiplier completion only follows a running multiply
  a_mm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> $past(mm_busy))
    else $error("multiplier done without busy");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

endmodule

### hdl/ratsm_elem_ram.sv
// Element store: one write port, one read port, registered read data.
// Depends on ratsm_pkg.
module ratsm_elem_ram import ratsm_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ELEMENTS,
  parameter int AW    = $clog2(DEF_MAX_ELEMENTS),
  parameter int W     = DEF_VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/ratsm_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
// Depends on ratsm_pkg. Requires a < m.
module ratsm_mulmod import ratsm_pkg::*; #(
  parameter int W = DEF_VALUE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, a_q, b_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    dbl, dbl_red, sum, sum_red;

  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    sum     = dbl_red + (b_q[W-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= {1'b0, m_i}) ? sum - {1'b0, m_i} : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= sum_red[W-1:0];
      b_q   <= {b_q[W-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

### bench/tb_range_affine_sum_tree_mod_core.sv
// Testbench for range_affine_sum_tree_mod_core: directed table, then random
// range load/multiply/add/sum transactions checked against a flat-array predictor.
// Depends on hdl/ratsm_pkg.sv and hdl/range_affine_sum_tree_mod_core.sv.
module tb_range_affine_sum_tree_mod_core;
  import ratsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NELEM = DEF_MAX_ELEMENTS;
  localparam int VBITS = DEF_VALUE_BITS;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [9:0]  first_index_i;
  logic [9:0]  last_index_i;
  logic [30:0] operand_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [30:0] range_sum_o;
  logic        range_error_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  range_affine_sum_tree_mod_core dut (.*);

  // One expected result transaction.
  typedef struct packed {
    logic [30:0] sum;
    logic        err;
  } sum_result_t;

  // Directed table row; has_fixed marks rows whose result is typed in here.
  typedef struct {
    action_e     act;
    int          first;
    int          last;
    logic [30:0] val;
    bit          has_fixed;
    sum_result_t fixed;
  } stim_row_t;

  sum_result_t pending_sums[$];

  // Shadow of the block: flat element array plus register copies.
  // Plain per-element arithmetic mod m matches the block, which also walks a flat store.
  logic [30:0] elem_shadow[NELEM];
  logic [30:0] mod_shadow;
  logic [10:0] count_shadow;

  bit failed;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned eff_mod();
    return (mod_shadow == 0) ? 1 : longint'(mod_shadow);
  endfunction

  function automatic int eff_count();
    return (count_shadow > NELEM) ? NELEM : int'(count_shadow);
  endfunction

  // Updates the shadow for one accepted transaction; has_res tells if a result follows.
  function automatic void predict_sum(input action_e act, input int first, input int last,
                                      input logic [30:0] val, output bit has_res,
                                      output sum_result_t res);
    longint unsigned m, v, acc;
    int cnt;
    bit bad;
    m = eff_mod();
    v = longint'(val) % m;
    cnt = eff_count();
    res = '0;
    has_res = 1'b0;
    if (act == ACT_LOAD) bad = first >= cnt;
    else bad = (first > last) || (last >= cnt);
    if (bad) begin
      res.err = 1'b1;
      has_res = 1'b1;
      return;
    end
    case (act)
      ACT_LOAD: elem_shadow[first] = 31'(v);
      ACT_MUL: for (int i = first; i <= last; i++)
        elem_shadow[i] = 31'((longint'(elem_shadow[i]) * v) % m);
      ACT_ADD: for (int i = first; i <= last; i++)
        elem_shadow[i] = 31'((longint'(elem_shadow[i]) + v) % m);
      default: begin
        acc = 0;
        for (int i = first; i <= last; i++) acc = (acc + elem_shadow[i]) % m;
        res.sum = 31'(acc);
        has_res = 1'b1;
      end
    endcase
  endfunction

  // Idle pattern follows overall progress: sender light / receiver heavy,
  // then swapped, then no idling at all.
  function automatic void set_idle_mode();
    if (items_sent < 420) begin
      send_idle_pct = 15;
      recv_idle_pct = 75;
    end else if (items_sent < 840) begin
      send_idle_pct = 75;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // Drives one input transaction; valid stays high into the next one unless a gap is rolled.
  task automatic send_item(input action_e act, input int first, input int last,
                           input logic [30:0] val, input bit has_fixed,
                           input sum_result_t fixed);
    bit has_res;
    sum_result_t res;
    in_valid_i      <= 1'b1;
    action_i        <= act;
    first_index_i   <= 10'(first);
    last_index_i    <= 10'(last);
    operand_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_sum(act, first, last, val, has_res, res);
    if (has_res) pending_sums.push_back(has_fixed ? fixed : res);
    items_sent++;
    set_idle_mode();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Waits out the last transaction, which may produce no result;
  // multiply walks run the serial multiplier once per element.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat ((VBITS + 8) * (eff_count() + 2) + 200) @(posedge clk_i);
  endtask

  // APB write: setup phase, then access phase; pready is always high.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MODULUS) begin
      mod_shadow = data[30:0];
      foreach (elem_shadow[i]) elem_shadow[i] = '0;
    end else begin
      count_shadow = data[10:0];
    end
  endtask

  function automatic logic [30:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'(eff_mod() - 1);
      3: return 31'($urandom_range(0, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  // Random transactions: mostly short in-range spans, some longer spans, some bad ranges.
  task automatic random_items(input int n);
    int cnt, first, last;
    action_e act;
    for (int k = 0; k < n; k++) begin
      cnt = eff_count();
      act = action_e'($urandom_range(3));
      if (cnt == 0 || $urandom_range(99) < 10) begin
        // broken range: reversed or past the element count
        if (cnt < NELEM && $urandom_range(1)) begin
          first = $urandom_range(0, NELEM - 1);
          last  = $urandom_range(cnt, NELEM - 1);
          if (act == ACT_LOAD) first = $urandom_range(cnt, NELEM - 1);
        end else begin
          first = $urandom_range(1, NELEM - 1);
          last  = $urandom_range(0, first - 1);
        end
      end else begin
        first = $urandom_range(0, cnt - 1);
        if (act == ACT_LOAD) last = $urandom_range(0, NELEM - 1);
        else if ($urandom_range(99) < 90)
          last = first + $urandom_range(0, 7);
        else
          last = $urandom_range(first, cnt - 1);
        if (act != ACT_LOAD && last > cnt - 1) last = cnt - 1;
        if (act == ACT_MUL && last - first > 64 && $urandom_range(3) != 0)
          last = first + 64;
      end
      send_item(act, first, last, pick_operand(), 1'b0, '0);
    end
  endtask

  // Result side: random stall on ready, compare each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (pending_sums.size() == 0) begin
          $error("unexpected result: range_sum %0d range_error %0d",
                 range_sum_o, range_error_o);
          failed = 1'b1;
        end else begin
          sum_result_t exp_r;
          exp_r = pending_sums.pop_front();
          if (range_sum_o !== exp_r.sum) begin
            $error("range_sum expected %0d actual %0d", exp_r.sum, range_sum_o);
            failed = 1'b1;
          end
          if (range_error_o !== exp_r.err) begin
            $error("range_error expected %0d actual %0d", exp_r.err, range_error_o);
            failed = 1'b1;
          end
        end
      end
    end else begin
      out_ready_i <= 1'b0;
    end
  end

  stim_row_t dir_rows[$];

  initial begin
    items_sent      = 0;
    send_idle_pct   = 15;
    recv_idle_pct   = 75;
    in_valid_i      = 1'b0;
    action_i        = ACT_LOAD;
    first_index_i   = '0;
    last_index_i    = '0;
    operand_value_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mod_shadow      = RESET_MODULUS;
    count_shadow    = RESET_COUNT;
    foreach (elem_shadow[i]) elem_shadow[i] = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at reset settings (modulus 2^31-1, 1024 elements).
    dir_rows = '{
      '{ACT_QUERY,    0, 1023, 31'd0,          1'b1, '{31'd0, 1'b0}},
      '{ACT_LOAD,     0,    0, 31'h7FFF_FFFF,  1'b0, '0},  // reduces to zero
      '{ACT_LOAD,  1023,    0, 31'h7FFF_FFFE,  1'b0, '0},
      '{ACT_LOAD,     5,    0, 31'd12345,      1'b0, '0},
      '{ACT_QUERY,    0, 1023, 31'd0,          1'b0, '0},
      '{ACT_ADD,      0, 1023, 31'd1000,       1'b0, '0},
      '{ACT_MUL,      0, 1023, 31'd2,          1'b0, '0},
      '{ACT_QUERY, 1023, 1023, 31'd0,          1'b0, '0},
      '{ACT_ADD,      3,    3, 31'h7FFF_FFFE,  1'b0, '0},
      '{ACT_MUL,      0,    0, 31'd0,          1'b0, '0},
      '{ACT_QUERY,    0,    0, 31'd0,          1'b1, '{31'd0, 1'b0}},
      '{ACT_QUERY,    5,    4, 31'd0,          1'b1, '{31'd0, 1'b1}},  // reversed
      '{ACT_ADD,     10,    9, 31'd7,          1'b1, '{31'd0, 1'b1}},
      '{ACT_MUL,   1023,    0, 31'd3,          1'b1, '{31'd0, 1'b1}},
      '{ACT_LOAD,  1023,  700, 31'd5,          1'b0, '0},  // last ignored
      '{ACT_QUERY,    0, 1023, 31'd0,          1'b0, '0},
      '{ACT_QUERY,  512,  511, 31'h7FFF_FFFF,  1'b1, '{31'd0, 1'b1}},
      '{ACT_ADD,      0, 1023, 31'h7FFF_FFFF,  1'b0, '0},  // adds zero
      '{ACT_MUL,    100,  131, 31'h7FFF_FFFE,  1'b0, '0},
      '{ACT_QUERY,  511,  512, 31'd0,          1'b0, '0},
      '{ACT_QUERY,   90,  140, 31'd0,          1'b0, '0}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].first, dir_rows[i].last,
                dir_rows[i].val, dir_rows[i].has_fixed, dir_rows[i].fixed);

    // Random phases over several register settings; count-only writes keep elements.
    drain();
    write_reg(REG_COUNT, 32'd32);
    random_items(200);
    drain();
    write_reg(REG_MODULUS, 32'd7);
    write_reg(REG_COUNT, 32'd16);
    random_items(200);
    drain();
    write_reg(REG_MODULUS, 32'd0);  // behaves as modulus one
    write_reg(REG_COUNT, 32'd8);
    random_items(120);
    drain();
    write_reg(REG_COUNT, 32'd2047);  // saturates to the full store
    random_items(120);
    drain();
    write_reg(REG_MODULUS, 32'd1000003);
    write_reg(REG_COUNT, 32'd1024);
    random_items(150);
    drain();
    write_reg(REG_COUNT, 32'd0);  // every range out of bounds
    random_items(40);
    drain();
    write_reg(REG_COUNT, 32'd24);
    random_items(200);
    drain();
    write_reg(REG_MODULUS, 32'h7FFF_FFFF);
    write_reg(REG_COUNT, 32'd1);
    random_items(60);
    drain();
    write_reg(REG_COUNT, 32'd5);
    random_items(140);
    drain();

    if (failed == 1'b0 && pending_sums.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (pending_sums.size() != 0)
        $error("%0d expected results never arrived", pending_sums.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ratsm_pkg.sv
hdl/ratsm_elem_ram.sv
hdl/ratsm_mulmod.sv
hdl/range_affine_sum_tree_mod_core.sv
bench/tb_range_affine_sum_tree_mod_core.sv
